/* design/sidl_pkg.sv */
`default_nettype none
package sidl_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned VALUE_BITS_DEF = 8;
	localparam int unsigned COUNT_BITS     = 5;
	localparam int unsigned STATUS_BITS    = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} sidl_op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} sidl_status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} sidl_cmd_t;

endpackage
`default_nettype wire

/* design/sidl_if.sv */
`default_nettype none
interface sidl_in_if #(
	parameter int unsigned VALUE_BITS = sidl_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sidl_out_if #(
	parameter int unsigned VALUE_BITS = sidl_pkg::VALUE_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [sidl_pkg::STATUS_BITS-1:0] status;
	logic [sidl_pkg::COUNT_BITS-1:0]  entry_count;
	logic [VALUE_BITS-1:0]            smallest_value;

	modport source (output valid, output status, output entry_count,
		output smallest_value, input ready);
	modport sink   (input valid, input status, input entry_count,
		input smallest_value, output ready);
endinterface
`default_nettype wire

/* design/sorted_insert_delete_list_core.sv */
// Throughput: one item per cycle while the output is not stalled; a result
// beat is registered for the cycle after its input beat is accepted. Every
// cell compares and shifts at once; the output frees when its beat is taken.
// Reset: arst_n clears every slot's used flag and the output valid, so the
// list starts empty; slot values stay unknown until written.
`default_nettype none
module sorted_insert_delete_list_core #(
	parameter int unsigned CAPACITY   = sidl_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = sidl_pkg::VALUE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sidl_in_if.sink    in_ch,
	sidl_out_if.source out_ch
);
	import sidl_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_BITS-1:0] cell_val  [CAPACITY];
	logic                  cell_used [CAPACITY];
	logic [CAPACITY-1:0]   cell_keep;
	logic [CAPACITY-1:0]   cell_match;

	logic         accept;
	logic         full;
	logic         found;
	sidl_cmd_t    cmd;
	sidl_status_t status_d;
	sidl_status_t status_q;
	logic         out_valid_q;
	logic [CNT_W-1:0] count_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign full        = cell_used[CAPACITY-1];
	assign found       = |cell_match;

	always_comb begin
		cmd      = '0;
		status_d = ST_DONE;
		if (in_ch.operation == OP_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				cmd.ins = accept;
			end
		end else begin
			if (!found) begin
				status_d = ST_ABSENT;
			end else begin
				cmd.del = accept;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  pk;
		logic [VALUE_BITS-1:0] lv;
		logic                  lu;
		logic [VALUE_BITS-1:0] rv;
		logic                  ru;

		if (i == 0) begin : g_head
			assign pk = 1'b1;
			assign lv = in_ch.value;
			assign lu = 1'b0;
		end else begin : g_body
			assign pk = cell_keep[i-1];
			assign lv = cell_val[i-1];
			assign lu = cell_used[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rv = in_ch.value;
			assign ru = 1'b0;
		end else begin : g_mid
			assign rv = cell_val[i+1];
			assign ru = cell_used[i+1];
		end

		sidl_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (in_ch.value),
			.prev_keep  (pk),
			.left_val   (lv),
			.left_used  (lu),
			.right_val  (rv),
			.right_used (ru),
			.val_q      (cell_val[i]),
			.used_q     (cell_used[i]),
			.keep       (cell_keep[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			status_q    <= ST_DONE;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.del) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// cells only change on an accept, which frees the output in the same cycle
	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.entry_count    = COUNT_BITS'(count_q);
	assign out_ch.smallest_value = cell_used[0] ? cell_val[0] : '0;

endmodule
`default_nettype wire

/* design/sidl_cell.sv */
`default_nettype none
module sidl_cell #(
	parameter int unsigned VALUE_BITS = sidl_pkg::VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sidl_pkg::sidl_cmd_t   cmd,
	input  wire logic [VALUE_BITS-1:0] key,
	input  wire logic                  prev_keep,
	input  wire logic [VALUE_BITS-1:0] left_val,
	input  wire logic                  left_used,
	input  wire logic [VALUE_BITS-1:0] right_val,
	input  wire logic                  right_used,
	output logic [VALUE_BITS-1:0]      val_q,
	output logic                       used_q,
	output logic                       keep,
	output logic                       match
);
	import sidl_pkg::*;

	logic take_key;
	logic take_left;
	logic take_right;

	// a used slot below the key stays where it is; the rest move
	assign keep       = used_q && (val_q < key);
	assign match      = used_q && (val_q == key);
	assign take_key   = cmd.ins && !keep && prev_keep;
	assign take_left  = cmd.ins && !keep && !prev_keep;
	assign take_right = cmd.del && !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (take_key) begin
			used_q <= 1'b1;
		end else if (take_left) begin
			used_q <= left_used;
		end else if (take_right) begin
			used_q <= right_used;
		end
	end

	always_ff @(posedge clk) begin
		if (take_key) begin
			val_q <= key;
		end else if (take_left) begin
			val_q <= left_val;
		end else if (take_right) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire

/* test/sorted_list_tracker.sv */
module sorted_list_tracker #(
	parameter int unsigned CAPACITY   = sidl_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = sidl_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sidl_in_if          in_ch,
	sidl_out_if         out_ch,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned items_taken,
	output int unsigned results_taken,
	output int unsigned full_hits,
	output int unsigned absent_hits
);
	import sidl_pkg::*;

	typedef struct packed {
		sidl_status_t              status;
		logic [COUNT_BITS-1:0]     count;
		logic [VALUE_BITS-1:0]     front;
	} list_result_t;

	logic [VALUE_BITS-1:0] ordered_keys [CAPACITY];
	int unsigned           key_count;
	list_result_t          awaited_results [$];

	// mirror one insert or delete on the ordered key store
	function automatic list_result_t apply_list_op(input sidl_op_t op,
			input logic [VALUE_BITS-1:0] key);
		list_result_t res;
		int unsigned  slot;
		int unsigned  i;
		res.status = ST_DONE;
		if (op == OP_INSERT) begin
			if (key_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				slot = 0;
				while (slot < key_count && ordered_keys[slot] < key)
					slot++;
				for (i = key_count; i > slot; i--)
					ordered_keys[i] = ordered_keys[i-1];
				ordered_keys[slot] = key;
				key_count++;
			end
		end else begin
			slot = 0;
			while (slot < key_count && ordered_keys[slot] != key)
				slot++;
			if (slot >= key_count) begin
				res.status = ST_ABSENT;
			end else begin
				for (i = slot; i + 1 < key_count; i++)
					ordered_keys[i] = ordered_keys[i+1];
				key_count--;
			end
		end
		res.count = key_count[COUNT_BITS-1:0];
		res.front = (key_count != 0) ? ordered_keys[0] : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		list_result_t want;
		int unsigned  errs;
		if (!arst_n) begin
			key_count = 0;
			awaited_results.delete();
			mismatches    <= 0;
			pending       <= 0;
			items_taken   <= 0;
			results_taken <= 0;
			full_hits     <= 0;
			absent_hits   <= 0;
		end else begin
			errs = 0;
			// a result beat always belongs to an earlier input beat, so retire first
			if (out_ch.valid && out_ch.ready) begin
				results_taken <= results_taken + 1;
				if (awaited_results.size() == 0) begin
					errs++;
					$display("%0t: result beat with nothing awaited (status %0d count %0d front %0d)",
						$time, out_ch.status, out_ch.entry_count, out_ch.smallest_value);
				end else begin
					want = awaited_results.pop_front();
					if (out_ch.status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d got %0d", $time, want.status,
							out_ch.status);
					end
					if (out_ch.entry_count !== want.count) begin
						errs++;
						$display("%0t: entry_count expected %0d got %0d", $time, want.count,
							out_ch.entry_count);
					end
					if (out_ch.smallest_value !== want.front) begin
						errs++;
						$display("%0t: smallest_value expected %0d got %0d", $time,
							want.front, out_ch.smallest_value);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = apply_list_op(sidl_op_t'(in_ch.operation), in_ch.value);
				awaited_results.push_back(want);
				items_taken <= items_taken + 1;
				if (want.status == ST_FULL)
					full_hits <= full_hits + 1;
				if (want.status == ST_ABSENT)
					absent_hits <= absent_hits + 1;
			end
			mismatches <= mismatches + errs;
			pending    <= awaited_results.size();
		end
	end
endmodule

/* test/sorted_insert_delete_list_core_tb.sv */
module sorted_insert_delete_list_core_tb;
	import sidl_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_ITEMS = 460;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned quiet_cycles = 0;

	int unsigned mismatches, pending, items_taken, results_taken, full_hits, absent_hits;

	logic [VALUE_BITS_DEF-1:0] recent_keys [$];

	sidl_in_if  in_ch ();
	sidl_out_if out_ch ();

	sorted_insert_delete_list_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sorted_list_tracker tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.mismatches    (mismatches),
		.pending       (pending),
		.items_taken   (items_taken),
		.results_taken (results_taken),
		.full_hits     (full_hits),
		.absent_hits   (absent_hits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_item(input sidl_op_t op, input logic [VALUE_BITS_DEF-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.value     <= key;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
	endtask

	// hold the input quiet until every awaited result has come back
	task automatic drain_list_results();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic send_random_items(input int unsigned total);
		int unsigned               sent;
		int unsigned               insert_pct;
		sidl_op_t                  op;
		logic [VALUE_BITS_DEF-1:0] key;
		insert_pct = 50;
		for (sent = 0; sent < total; sent++) begin
			// swing the mix so the list keeps filling up and draining
			if (sent % 40 == 0) begin
				case ($urandom_range(3))
					0: insert_pct = 15;
					1: insert_pct = 50;
					2: insert_pct = 85;
					default: insert_pct = 97;
				endcase
			end
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
			case ($urandom_range(9))
				0, 1, 2, 3: key = VALUE_BITS_DEF'($urandom_range(15));
				4: key = ($urandom_range(1) != 0) ? '1 : '0;
				default: key = VALUE_BITS_DEF'($urandom);
			endcase
			if (op == OP_DELETE && recent_keys.size() != 0 && $urandom_range(1) != 0)
				key = recent_keys[$urandom_range(recent_keys.size() - 1)];
			if (op == OP_INSERT) begin
				recent_keys.push_back(key);
				if (recent_keys.size() > 32)
					void'(recent_keys.pop_front());
			end
			send_item(op, key);
		end
	endtask

	initial begin : receiver
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_ch.valid = 1'b0;
		in_ch.operation = OP_INSERT;
		in_ch.value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, then fill to capacity with extremes and duplicates
		send_item(OP_DELETE, 8'd0);
		send_item(OP_DELETE, 8'd255);
		send_item(OP_INSERT, 8'd255);
		send_item(OP_INSERT, 8'd0);
		send_item(OP_INSERT, 8'd128);
		send_item(OP_INSERT, 8'd0);
		send_item(OP_INSERT, 8'd64);
		send_item(OP_INSERT, 8'd192);
		send_item(OP_INSERT, 8'd1);
		send_item(OP_INSERT, 8'd254);
		send_item(OP_INSERT, 8'd127);
		send_item(OP_INSERT, 8'd129);
		send_item(OP_INSERT, 8'd32);
		send_item(OP_INSERT, 8'd224);
		send_item(OP_INSERT, 8'd16);
		send_item(OP_INSERT, 8'd240);
		send_item(OP_INSERT, 8'd8);
		send_item(OP_INSERT, 8'd248);
		// full list: rejected inserts, misses, then take off the ends
		send_item(OP_INSERT, 8'd0);
		send_item(OP_INSERT, 8'd255);
		send_item(OP_DELETE, 8'd100);
		send_item(OP_DELETE, 8'd0);
		send_item(OP_DELETE, 8'd255);
		send_item(OP_DELETE, 8'd0);
		send_item(OP_DELETE, 8'd0);
		drain_list_results();

		send_random_items(PHASE_ITEMS / 2);
		hold_requests = hold_requests + 1;
		send_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
		drain_list_results();

		send_idle_pct = 71;
		send_random_items(PHASE_ITEMS);
		drain_list_results();

		send_idle_pct = 0;
		stall_pct = 71;
		send_random_items(PHASE_ITEMS);
		drain_list_results();

		send_idle_pct = 27;
		stall_pct = 27;
		send_random_items(PHASE_ITEMS);
		drain_list_results();

		stall_pct = 0;
		repeat (5) @(posedge clk);
		$display("%0d beats in, %0d results compared", items_taken, results_taken);
		$display("%0d inserts hit a full list, %0d deletes missed", full_hits, absent_hits);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
